// ===== design/msce_pkg.sv =====
// Shared types, mode codes, polynomials and bit-serial CRC byte updates
// for the multi-standard CRC engine. No dependencies.
package msce_pkg;

	// Field widths
	localparam int unsigned CrcW    = 64;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned ModeW   = 3;
	localparam int unsigned CfgIdxW = 1;

	typedef logic [ModeW-1:0] crc_mode_t;
	typedef logic [CrcW-1:0]  crc_word_t;
	typedef logic [ByteW-1:0] byte_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	// Mode codes
	localparam crc_mode_t ModeCrc8   = 3'd0;
	localparam crc_mode_t ModeCrc16  = 3'd1;
	localparam crc_mode_t ModeCcitt  = 3'd2;
	localparam crc_mode_t ModeKermit = 3'd3;
	localparam crc_mode_t ModeDnp    = 3'd4;
	localparam crc_mode_t ModeSick   = 3'd5;
	localparam crc_mode_t ModeCrc32  = 3'd6;
	localparam crc_mode_t ModeCrc64  = 3'd7;

	// Configuration register indexes
	localparam cfg_idx_t RegMode = 1'b0;
	localparam cfg_idx_t RegSeed = 1'b1;

	localparam crc_mode_t ModeReset = ModeCrc32;

	// Polynomials
	localparam logic [7:0]  PolyCrc8   = 8'h31;
	localparam logic [15:0] PolyCrc16  = 16'hA001;
	localparam logic [15:0] PolyCcitt  = 16'h1021;
	localparam logic [15:0] PolyKermit = 16'h8408;
	localparam logic [15:0] PolyDnp    = 16'hA6BC;
	localparam logic [15:0] PolySick   = 16'h8005;
	localparam logic [31:0] PolyCrc32  = 32'hEDB88320;
	localparam logic [63:0] PolyCrc64  = 64'h42F0E1EBA9EA3693;

	// Configuration register contents
	typedef struct packed {
		crc_mode_t mode;
		crc_word_t seed;
	} cfg_t;

	// MSB-first byte update on a left-aligned 64-bit register
	function automatic logic [63:0] crc_msb_byte(logic [63:0] crc, byte_t data,
			logic [63:0] poly);
		logic [63:0] c;
		c = crc ^ {data, 56'b0};
		for (int i = 0; i < 8; i++) begin
			c = c[63] ? ({c[62:0], 1'b0} ^ poly) : {c[62:0], 1'b0};
		end
		return c;
	endfunction

	// Reflected byte update on a right-aligned 32-bit register
	function automatic logic [31:0] crc_refl_byte(logic [31:0] crc, byte_t data,
			logic [31:0] poly);
		logic [31:0] c;
		c = crc ^ {24'b0, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/msce_cfg_regs.sv =====
// Configuration registers (mode and seed) of the CRC engine.
// Depends on msce_pkg.
module msce_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  msce_pkg::cfg_idx_t  cfg_index,
	input  msce_pkg::crc_word_t cfg_data,
	output msce_pkg::cfg_t      cfg
);
	import msce_pkg::*;

	crc_mode_t mode_q;
	crc_word_t seed_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModeReset;
			seed_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegMode: mode_q <= cfg_data[ModeW-1:0];
				RegSeed: seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.mode = mode_q;
	assign cfg.seed = seed_q;

endmodule

// ===== design/msce_update.sv =====
// Single-byte CRC update for all eight modes, purely combinational.
// Depends on msce_pkg.
module msce_update (
	input  msce_pkg::cfg_t      cfg,
	input  msce_pkg::crc_word_t running_crc,
	input  msce_pkg::byte_t     previous_byte,
	input  msce_pkg::byte_t     data_byte,
	input  logic                first_of_message,
	output msce_pkg::crc_word_t crc_next
);
	import msce_pkg::*;

	crc_word_t   base;
	byte_t       prv;
	logic [63:0] msb;
	logic [31:0] refl;
	logic [15:0] sick;

	always_comb begin
		// First word of a message restarts from the seed
		base = first_of_message ? cfg.seed : running_crc;
		prv  = first_of_message ? '0 : previous_byte;
		msb  = '0;
		refl = '0;
		sick = '0;
		crc_next = '0;
		case (cfg.mode)
			ModeCrc8: begin
				msb = crc_msb_byte({base[7:0], 56'b0}, data_byte, {PolyCrc8, 56'b0});
				crc_next = {56'b0, msb[63:56]};
			end
			ModeCcitt: begin
				msb = crc_msb_byte({base[15:0], 48'b0}, data_byte, {PolyCcitt, 48'b0});
				crc_next = {48'b0, msb[63:48]};
			end
			ModeCrc64: begin
				msb = crc_msb_byte(base, data_byte, PolyCrc64);
				crc_next = msb;
			end
			ModeCrc16: begin
				refl = crc_refl_byte({16'b0, base[15:0]}, data_byte, {16'b0, PolyCrc16});
				crc_next = {48'b0, refl[15:0]};
			end
			ModeKermit: begin
				refl = crc_refl_byte({16'b0, base[15:0]}, data_byte, {16'b0, PolyKermit});
				crc_next = {48'b0, refl[15:0]};
			end
			ModeDnp: begin
				refl = crc_refl_byte({16'b0, base[15:0]}, data_byte, {16'b0, PolyDnp});
				crc_next = {48'b0, refl[15:0]};
			end
			ModeCrc32: begin
				refl = crc_refl_byte(base[31:0], data_byte, PolyCrc32);
				crc_next = {32'b0, refl};
			end
			ModeSick: begin
				// one shift step, then fold in current and previous byte
				sick = base[15] ? ({base[14:0], 1'b0} ^ PolySick) : {base[14:0], 1'b0};
				sick = sick ^ {prv, data_byte};
				crc_next = {48'b0, sick};
			end
			default: crc_next = '0;
		endcase
	end

endmodule

// ===== design/multi_standard_crc_engine.sv =====
// Multi-standard CRC engine, top level: input register, CRC update, result register.
// An accepted word moves from the input register into the result register once that
// register can load, and is presented from there with out_valid.
// Throughput: one byte per cycle, limited by the single-pass CRC update between
// the input register and the result register; out_stall back-pressures in_stall.
// Reset (arst_n, asynchronous, active low): pipeline empty, running CRC and
// previous byte zero, mode CRC-32, seed zero.
module multi_standard_crc_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  msce_pkg::byte_t     data_byte,
	input  logic                first_of_message,
	input  logic                last_of_message,
	output logic                out_valid,
	input  logic                out_stall,
	output msce_pkg::crc_word_t crc_value,
	output logic                crc_final,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  msce_pkg::cfg_idx_t  cfg_index,
	input  msce_pkg::crc_word_t cfg_data
);
	import msce_pkg::*;

	cfg_t      cfg;
	logic      valid_s1;
	byte_t     data_s1;
	logic      first_s1;
	logic      last_s1;
	logic      valid_s2;
	crc_word_t crc_s2;
	logic      final_s2;
	crc_word_t running_crc_q;
	byte_t     prev_byte_q;
	crc_word_t crc_next;
	logic      s2_load;
	logic      s1_adv;

	msce_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	msce_update u_upd (
		.cfg              (cfg),
		.running_crc      (running_crc_q),
		.previous_byte    (prev_byte_q),
		.data_byte        (data_s1),
		.first_of_message (first_s1),
		.crc_next         (crc_next)
	);

	// Flow control
	assign s2_load  = !valid_s2 || !out_stall;
	assign s1_adv   = valid_s1 && s2_load;
	assign in_stall = valid_s1 && !s2_load;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1  <= data_byte;
			first_s1 <= first_of_message;
			last_s1  <= last_of_message;
		end
	end

	// Running state advances as each word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			prev_byte_q   <= '0;
		end else if (s1_adv) begin
			running_crc_q <= crc_next;
			prev_byte_q   <= data_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			crc_s2   <= crc_next;
			final_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign crc_value = crc_s2;
	assign crc_final = final_s2;

endmodule

// ===== design/msce_checker.sv =====
// Port-level checker for the CRC engine, bound to the top level.
// Depends on msce_pkg; tracks the mode register from configuration writes.
module msce_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input msce_pkg::crc_word_t crc_value,
	input logic                crc_final,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input msce_pkg::cfg_idx_t  cfg_index,
	input msce_pkg::crc_word_t cfg_data
);
	import msce_pkg::*;

	crc_mode_t mode_q;

	// Shadow of the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModeReset;
		end else if (cfg_valid && cfg_ready && cfg_index == RegMode) begin
			mode_q <= cfg_data[ModeW-1:0];
		end
	end

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(crc_value) && $stable(crc_final))
		else $error("result word changed while stalled");

	// Input only back-pressures when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// An accepted word is followed by a pending result word
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("accepted word produced no pending result");

	// Narrow modes give zero-extended results
	a_zero_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q != ModeCrc64 |->
			crc_value[63:32] == '0 && (mode_q == ModeCrc32 || crc_value[31:16] == '0) &&
			(mode_q != ModeCrc8 || crc_value[15:8] == '0))
		else $error("result not zero-extended for mode width");

endmodule

bind multi_standard_crc_engine msce_checker u_msce_checker (.*);

// ===== test/tb_multi_standard_crc_engine.sv =====
// Self-checking testbench for the multi-standard CRC engine: directed table, then random messages.
// Depends on msce_pkg and multi_standard_crc_engine; checks every result word (model or typed).
`timescale 1ns / 100ps

module tb_multi_standard_crc_engine;
	import msce_pkg::*;

	localparam int unsigned RandomItems = 430;
	localparam int unsigned SettleCycles = 3;   // pipeline: input and result registers
	localparam int unsigned StallLimit = 1000;
	localparam int unsigned IdlePct = 34;
	localparam int unsigned MaxReports = 10;

	// Directed row: config for the word, the word itself, optional typed expectation
	typedef struct packed {
		crc_mode_t mode;
		crc_word_t seed;
		byte_t     data;
		logic      first;
		logic      last;
		logic      typed;
		crc_word_t crc;
	} crc_row_t;

	typedef struct packed {
		crc_word_t crc;
		logic      fin;
	} crc_result_t;

	localparam crc_word_t AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int unsigned NumRows = 21;

	// Rows with typed results are after reset, zero seed on zero data, and the sick
	// mode folding a byte into a cleared CRC.
	crc_row_t dir_rows [NumRows] = '{
		'{ModeCrc32,  64'h0,   8'h00, 1'b0, 1'b0, 1'b1, 64'h0},
		'{ModeCrc32,  AllOnes, 8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
		'{ModeCrc32,  AllOnes, 8'h00, 1'b0, 1'b1, 1'b0, 64'h0},
		'{ModeCrc8,   64'h0,   8'h00, 1'b1, 1'b1, 1'b1, 64'h0},
		'{ModeCrc8,   AllOnes, 8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
		'{ModeCrc16,  AllOnes, 8'h01, 1'b1, 1'b0, 1'b0, 64'h0},
		'{ModeCrc16,  AllOnes, 8'h80, 1'b0, 1'b1, 1'b0, 64'h0},
		'{ModeCcitt,  AllOnes, 8'h31, 1'b1, 1'b1, 1'b0, 64'h0},
		'{ModeKermit, 64'h0,   8'h31, 1'b1, 1'b1, 1'b0, 64'h0},
		'{ModeDnp,    64'h0,   8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
		'{ModeDnp,    64'h0,   8'h7E, 1'b0, 1'b1, 1'b0, 64'h0},
		'{ModeSick,   64'h0,   8'hFF, 1'b1, 1'b0, 1'b1, 64'hFF},
		'{ModeSick,   64'h0,   8'h00, 1'b0, 1'b0, 1'b0, 64'h0},
		'{ModeSick,   64'h0,   8'hAA, 1'b0, 1'b1, 1'b0, 64'h0},
		'{ModeCrc64,  AllOnes, 8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
		'{ModeCrc64,  AllOnes, 8'h00, 1'b0, 1'b1, 1'b0, 64'h0},
		// mode switched mid-message, no reload
		'{ModeCrc8,   AllOnes, 8'h5A, 1'b0, 1'b0, 1'b0, 64'h0},
		'{ModeCrc32,  AllOnes, 8'h5A, 1'b0, 1'b0, 1'b0, 64'h0},
		'{ModeSick,   AllOnes, 8'h01, 1'b0, 1'b1, 1'b0, 64'h0},
		'{ModeCrc64,  64'h0,   8'h00, 1'b1, 1'b1, 1'b1, 64'h0},
		'{ModeKermit, 64'hFFFF_0000_1234_ABCD, 8'h00, 1'b1, 1'b1, 1'b0, 64'h0}
	};

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	byte_t     data_byte = '0;
	logic      first_of_message = 1'b0;
	logic      last_of_message = 1'b0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	crc_word_t crc_value;
	logic      crc_final;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index = RegMode;
	crc_word_t cfg_data = '0;

	// Local copy of the engine's registers and state
	crc_mode_t mode_reg = ModeReset;
	crc_word_t seed_reg = '0;
	crc_word_t crc_state = '0;
	byte_t     prev_byte = '0;

	crc_result_t pending_crcs [$];
	int unsigned n_mismatch = 0;
	int unsigned idle_cycles = 0;
	bit          steady = 1'b0;   // no idling on either side while set

	multi_standard_crc_engine dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.crc_value        (crc_value),
		.crc_final        (crc_final),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Fold one byte into the running CRC under the current mode; returns the new CRC
	function automatic crc_word_t fold_byte(byte_t d, logic first);
		crc_word_t   mask;
		crc_word_t   poly;
		crc_word_t   c;
		int unsigned w;
		logic        refl;
		refl = 1'b0;
		case (mode_reg)
			ModeCrc8: begin
				w = 8; poly = crc_word_t'(PolyCrc8);
			end
			ModeCrc16: begin
				w = 16; poly = crc_word_t'(PolyCrc16); refl = 1'b1;
			end
			ModeCcitt: begin
				w = 16; poly = crc_word_t'(PolyCcitt);
			end
			ModeKermit: begin
				w = 16; poly = crc_word_t'(PolyKermit); refl = 1'b1;
			end
			ModeDnp: begin
				w = 16; poly = crc_word_t'(PolyDnp); refl = 1'b1;
			end
			ModeSick: begin
				w = 16; poly = crc_word_t'(PolySick);
			end
			ModeCrc32: begin
				w = 32; poly = crc_word_t'(PolyCrc32); refl = 1'b1;
			end
			default: begin
				w = 64; poly = PolyCrc64;
			end
		endcase
		mask = (w == 64) ? AllOnes : ((64'd1 << w) - 64'd1);
		if (first) begin
			crc_state = seed_reg & mask;
			prev_byte = '0;
		end
		c = crc_state & mask;
		if (mode_reg == ModeSick) begin
			// one shift, then the byte pair
			c = (c[15] ? ((c << 1) ^ poly) : (c << 1)) & mask;
			c = c ^ {48'b0, prev_byte, d};
		end else if (refl) begin
			c = c ^ crc_word_t'(d);
			for (int i = 0; i < 8; i++)
				c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end else begin
			c = c ^ (crc_word_t'(d) << (w - 8));
			for (int i = 0; i < 8; i++)
				c = (c[w-1] ? ((c << 1) ^ poly) : (c << 1)) & mask;
		end
		crc_state = c & mask;
		prev_byte = d;
		return crc_state;
	endfunction

	function automatic void report(string msg);
		n_mismatch++;
		if (n_mismatch <= MaxReports)
			$display("%0t: %s", $time, msg);
	endfunction

	// Send one data word; a typed expectation replaces the model's value
	task automatic send_byte(byte_t d, logic f, logic l, logic typed, crc_word_t typed_crc);
		crc_word_t model_crc;
		if (!steady && $urandom_range(99) < IdlePct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		first_of_message <= f;
		last_of_message <= l;
		do @(posedge clk); while (in_stall);
		model_crc = fold_byte(d, f);
		pending_crcs.push_back({typed ? typed_crc : model_crc, l});
	endtask

	// Stop sending and wait for the pipeline to empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_crcs.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic cfg_push(cfg_idx_t idx, crc_word_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == RegMode)
			mode_reg = crc_mode_t'(val);
		else
			seed_reg = val;
	endtask

	// Register writes happen only with the engine drained
	task automatic configure(bit wr_mode, crc_mode_t m, bit wr_seed, crc_word_t s);
		settle();
		if (wr_mode)
			cfg_push(RegMode, crc_word_t'(m));
		if (wr_seed)
			cfg_push(RegSeed, s);
		cfg_valid <= 1'b0;
	endtask

	// Random back-pressure on the result side
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IdlePct);
	end

	// Result checker
	always @(posedge clk) begin
		crc_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_crcs.size() == 0) begin
				report($sformatf("unexpected result word crc=%h final=%b", crc_value, crc_final));
			end else begin
				exp_r = pending_crcs.pop_front();
				if (crc_value !== exp_r.crc || crc_final !== exp_r.fin)
					report($sformatf("expected crc=%h final=%b, got crc=%h final=%b",
						exp_r.crc, exp_r.fin, crc_value, crc_final));
			end
		end
	end

	// Watchdog: too long without any word moving on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned n_random;
		int unsigned len;
		int unsigned pick;
		crc_word_t   seed_v;
		n_random = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != mode_reg || dir_rows[i].seed != seed_reg)
				configure(dir_rows[i].mode != mode_reg, dir_rows[i].mode,
					dir_rows[i].seed != seed_reg, dir_rows[i].seed);
			send_byte(dir_rows[i].data, dir_rows[i].first, dir_rows[i].last,
				dir_rows[i].typed, dir_rows[i].crc);
		end

		// Random messages, mostly well formed
		while (n_random < RandomItems) begin
			steady = (n_random >= 150 && n_random < 250);
			if ($urandom_range(99) < 20) begin
				pick = $urandom_range(2);
				case ($urandom_range(3))
					0: seed_v = '0;
					1: seed_v = AllOnes;
					default: seed_v = {$urandom, $urandom};
				endcase
				configure(pick != 1, crc_mode_t'($urandom_range(7)), pick != 0, seed_v);
			end
			if ($urandom_range(99) < 85) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
				for (int k = 0; k < len; k++)
					send_byte(byte_t'($urandom), k == 0, k == len - 1, 1'b0, '0);
			end else begin
				// stray flags, sometimes a mode switch inside the message
				len = $urandom_range(6, 1);
				for (int k = 0; k < len; k++) begin
					if (k == 1 && $urandom_range(3) == 0)
						configure(1'b1, crc_mode_t'($urandom_range(7)), 1'b0, '0);
					send_byte(byte_t'($urandom), 1'($urandom_range(1)),
						1'($urandom_range(1)), 1'b0, '0);
				end
			end
			n_random += len;
		end
		steady = 1'b0;

		settle();
		if (n_mismatch == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
